// ===== src/rpc_pkg.sv =====
package rpc_pkg;

	// Fraction bits carried by the datapath below the integer coordinate.
	localparam int GUARD = 6;

	// Reciprocal of the CORDIC gain, scaled by 2^24.
	localparam int INV_GAIN_W = 24;
	localparam logic [INV_GAIN_W-1:0] INV_GAIN = 24'd10188014;

	localparam int ANGLE_W = 16;
	localparam int PHASE_W = 32;
	localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

	// Request kinds.
	localparam logic REQ_TO_POLAR = 1'b0;
	localparam logic REQ_TO_RECT  = 1'b1;

	// Angles of the four axes in binary units.
	localparam logic [ANGLE_W-1:0] ANG_EAST  = 16'h0000;
	localparam logic [ANGLE_W-1:0] ANG_NORTH = 16'h4000;
	localparam logic [ANGLE_W-1:0] ANG_WEST  = 16'h8000;
	localparam logic [ANGLE_W-1:0] ANG_SOUTH = 16'hC000;

	// Control that travels with an item from cell to cell.
	typedef struct packed {
		logic valid;
		logic vect;
	} ctl_t;

	// Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
	function automatic logic [PHASE_W-1:0] atan_lut(input logic [4:0] idx);
		logic [PHASE_W-1:0] a;
		case (idx)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			5'd31: a = 32'h00000000;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/rpc_prep.sv =====
module rpc_prep
	import rpc_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int DW = COORD_WIDTH + GUARD + 3,
	parameter int SW = 1 + 3 * COORD_WIDTH + ANGLE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          req_type,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic [COORD_WIDTH-2:0]        radius_in,
	input  logic [ANGLE_W-1:0]            angle_in,
	output ctl_t                          ctl,
	output logic signed [DW-1:0]          x,
	output logic signed [DW-1:0]          y,
	output logic [PHASE_W-1:0]            z,
	output logic [SW-1:0]                 side
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = W - 1 + INV_GAIN_W;
	localparam logic [PW:0] ROT_RND = (PW+1)'(1 << 17);

	logic                 vect;
	logic                 x_zero, y_zero, x_neg, y_neg;
	logic [W-1:0]         abs_x, abs_y;
	logic signed [DW-1:0] x_ext, y_ext, vx, vy;
	logic [PW-1:0]        prod;
	logic [PW:0]          prod_rnd;
	logic signed [DW-1:0] rx, rxs;
	logic [PHASE_W-1:0]   rz0, rz;
	logic                 back_half, axis;
	logic signed [W-1:0]  rp, rn;

	logic                 spec;
	logic [W-1:0]         spec_rad;
	logic [ANGLE_W-1:0]   spec_ang;
	logic signed [W-1:0]  spec_x, spec_y;

	ctl_t                 ctl_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	logic [PHASE_W-1:0]   z_s1;
	logic [SW-1:0]        side_s1;

	always_comb begin
		vect   = (req_type == REQ_TO_POLAR);

		// Vectoring: fold the left half plane onto the right one.
		x_zero = (x_in == '0);
		y_zero = (y_in == '0);
		x_neg  = x_in[W-1];
		y_neg  = y_in[W-1];
		abs_x  = x_neg ? (~x_in + 1'b1) : x_in;
		abs_y  = y_neg ? (~y_in + 1'b1) : y_in;
		x_ext  = DW'(x_in);
		y_ext  = DW'(y_in);
		vx     = (x_neg ? -x_ext : x_ext) <<< GUARD;
		vy     = (x_neg ? -y_ext : y_ext) <<< GUARD;

		// Rotation: start from the radius with the gain taken out.
		prod      = PW'(radius_in) * PW'(INV_GAIN);
		prod_rnd  = {1'b0, prod} + ROT_RND;
		rx        = $signed(DW'({1'b0, prod_rnd[PW:18]}));
		rz0       = {angle_in, 16'h0000};
		back_half = rz0[PHASE_W-1] ^ rz0[PHASE_W-2];
		rz        = back_half ? (rz0 ^ HALF_TURN) : rz0;
		rxs       = back_half ? -rx : rx;
		axis      = (angle_in == ANG_EAST) || (angle_in == ANG_NORTH) ||
		            (angle_in == ANG_WEST) || (angle_in == ANG_SOUTH);
		rp        = $signed({1'b0, radius_in});
		rn        = -rp;

		if (vect) begin
			spec     = x_zero | y_zero;
			spec_rad = y_zero ? abs_x : abs_y;
			if (y_zero) begin
				spec_ang = x_neg ? ANG_WEST : ANG_EAST;
			end else begin
				spec_ang = y_neg ? ANG_SOUTH : ANG_NORTH;
			end
			spec_x   = '0;
			spec_y   = '0;
		end else begin
			spec     = axis;
			spec_rad = '0;
			spec_ang = '0;
			spec_x   = (angle_in == ANG_EAST) ? rp : ((angle_in == ANG_WEST) ? rn : '0);
			spec_y   = (angle_in == ANG_NORTH) ? rp : ((angle_in == ANG_SOUTH) ? rn : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.vect  <= vect;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= vect ? vx : rxs;
		y_s1    <= vect ? vy : '0;
		z_s1    <= vect ? (x_neg ? HALF_TURN : '0) : rz;
		side_s1 <= {spec, spec_rad, spec_ang, spec_x, spec_y};
	end

	assign ctl  = ctl_s1;
	assign x    = x_s1;
	assign y    = y_s1;
	assign z    = z_s1;
	assign side = side_s1;

endmodule

// ===== src/rpc_cell.sv =====
module rpc_cell
	import rpc_pkg::*;
#(
	parameter int DW  = 25,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl_a,
	input  logic signed [DW-1:0] x_a,
	input  logic signed [DW-1:0] y_a,
	input  logic [PHASE_W-1:0]   z_a,
	output ctl_t                 ctl_b,
	output logic signed [DW-1:0] x_b,
	output logic signed [DW-1:0] y_b,
	output logic [PHASE_W-1:0]   z_b
);

	localparam logic [PHASE_W-1:0] ANGLE = atan_lut(5'(IDX));

	logic signed [DW-1:0] dx, dy;
	logic                 ccw;
	ctl_t                 ctl_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	logic [PHASE_W-1:0]   z_s1;

	// Vectoring steers y towards zero, rotation steers the phase towards zero.
	always_comb begin
		dx  = y_a >>> IDX;
		dy  = x_a >>> IDX;
		ccw = ctl_a.vect ? y_a[DW-1] : ~z_a[PHASE_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_a;
		end
	end

	always_ff @(posedge clk) begin
		if (ccw) begin
			x_s1 <= x_a - dx;
			y_s1 <= y_a + dy;
			z_s1 <= z_a - ANGLE;
		end else begin
			x_s1 <= x_a + dx;
			y_s1 <= y_a - dy;
			z_s1 <= z_a + ANGLE;
		end
	end

	assign ctl_b = ctl_s1;
	assign x_b   = x_s1;
	assign y_b   = y_s1;
	assign z_b   = z_s1;

endmodule

// ===== src/rpc_post.sv =====
module rpc_post
	import rpc_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int DW = COORD_WIDTH + GUARD + 3,
	parameter int SW = 1 + 3 * COORD_WIDTH + ANGLE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctl_t                          ctl,
	input  logic signed [DW-1:0]          x,
	input  logic signed [DW-1:0]          y,
	input  logic [PHASE_W-1:0]            z,
	input  logic [SW-1:0]                 side,
	output logic                          done,
	output logic [COORD_WIDTH-1:0]        radius_out,
	output logic [ANGLE_W-1:0]            angle_out,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic                          kind_out
);

	localparam int W  = COORD_WIDTH;
	localparam int MW = DW - 1 + INV_GAIN_W;
	localparam int RW = MW - 29;
	localparam logic signed [DW-1:0] OUT_RND = DW'(1 << (GUARD - 1));
	localparam logic [MW:0] RAD_RND = (MW+1)'(1 << 29);
	localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

	logic [DW-2:0]        x_pos;
	logic signed [DW-1:0] xr, yr;
	logic [ANGLE_W-1:0]   ang;

	ctl_t                 ctl_s1;
	logic [MW-1:0]        mul_s1;
	logic signed [DW-1:0] xr_s1, yr_s1;
	logic [ANGLE_W-1:0]   ang_s1;
	logic [SW-1:0]        side_s1;

	logic [MW:0]          rad_sum;
	logic [RW-1:0]        rad_full;
	logic [W-1:0]         rad_sat;
	logic signed [W-1:0]  xs, ys;
	logic                 spec;
	logic [W-1:0]         spec_rad;
	logic [ANGLE_W-1:0]   spec_ang;
	logic signed [W-1:0]  spec_x, spec_y;

	logic                 done_q;
	logic [W-1:0]         radius_s2;
	logic [ANGLE_W-1:0]   angle_s2;
	logic signed [W-1:0]  x_s2, y_s2;
	logic                 kind_s2;

	// First stage: gain correction product, rounding of the phase and rounding of the rotated vector.
	always_comb begin
		x_pos = x[DW-1] ? '0 : x[DW-2:0];
		xr    = (x + OUT_RND) >>> GUARD;
		yr    = (y + OUT_RND) >>> GUARD;
		ang   = z[PHASE_W-1:PHASE_W-ANGLE_W] + ANGLE_W'(z[PHASE_W-ANGLE_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1  <= MW'(x_pos) * MW'(INV_GAIN);
		xr_s1   <= xr;
		yr_s1   <= yr;
		ang_s1  <= ang;
		side_s1 <= side;
	end

	// Second stage: saturation and choice between computed and exact results.
	always_comb begin
		rad_sum  = {1'b0, mul_s1} + RAD_RND;
		rad_full = rad_sum[MW:30];
		rad_sat  = (|rad_full[RW-1:W]) ? '1 : rad_full[W-1:0];

		if ((&xr_s1[DW-1:W-1]) || !(|xr_s1[DW-1:W-1])) begin
			xs = xr_s1[W-1:0];
		end else begin
			xs = xr_s1[DW-1] ? S_MIN : S_MAX;
		end
		if ((&yr_s1[DW-1:W-1]) || !(|yr_s1[DW-1:W-1])) begin
			ys = yr_s1[W-1:0];
		end else begin
			ys = yr_s1[DW-1] ? S_MIN : S_MAX;
		end

		spec     = side_s1[SW-1];
		spec_rad = side_s1[SW-2 -: W];
		spec_ang = side_s1[SW-2-W -: ANGLE_W];
		spec_x   = side_s1[2*W-1:W];
		spec_y   = side_s1[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vect) begin
			radius_s2 <= spec ? spec_rad : rad_sat;
			angle_s2  <= spec ? spec_ang : ang_s1;
			x_s2      <= '0;
			y_s2      <= '0;
			kind_s2   <= REQ_TO_POLAR;
		end else begin
			radius_s2 <= '0;
			angle_s2  <= '0;
			x_s2      <= spec ? spec_x : xs;
			y_s2      <= spec ? spec_y : ys;
			kind_s2   <= REQ_TO_RECT;
		end
	end

	assign done       = done_q;
	assign radius_out = radius_s2;
	assign angle_out  = angle_s2;
	assign x_out      = x_s2;
	assign y_out      = y_s2;
	assign kind_out   = kind_s2;

endmodule

// ===== src/rect_polar_converter.sv =====
// Results pass from the front stage through the row of CORDIC cells and the back end to done.
// Throughput: one item per cycle; busy stays low, since every stage moves on each clock.
// The rate is set by the row of CORDIC cells, one cell per iteration, each a register stage.
// Reset (arst_n low, asynchronous) clears the valid flags of every stage; data is not reset.
// Results leave on done for exactly one cycle; the receiver cannot stall them.
module rect_polar_converter
	import rpc_pkg::*;
#(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic [COORD_WIDTH-2:0]        radius_in,
	input  logic [ANGLE_W-1:0]            angle_in,
	output logic                          done,
	output logic [COORD_WIDTH-1:0]        radius_out,
	output logic [ANGLE_W-1:0]            angle_out,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic                          kind_out
);

	// Datapath width: the coordinate, the guard fraction bits, and headroom for
	// the CORDIC gain and the diagonal of the square.
	localparam int DW = COORD_WIDTH + GUARD + 3;
	// Side information: the exact-result flag and the exact results themselves.
	localparam int SW = 1 + 3 * COORD_WIDTH + ANGLE_W;

	logic                 accept;
	ctl_t                 ctl_c [CORDIC_STAGES+1];
	logic signed [DW-1:0] x_c   [CORDIC_STAGES+1];
	logic signed [DW-1:0] y_c   [CORDIC_STAGES+1];
	logic [PHASE_W-1:0]   z_c   [CORDIC_STAGES+1];
	logic [SW-1:0]        side_p;
	logic [SW-1:0]        side_q [CORDIC_STAGES];

	// The pipeline never refuses an item, so busy is constantly low.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Front stage: picks vectoring or rotation, folds the input into the right
	// half plane (vectoring) or the front half turn (rotation), removes the
	// gain from the radius, and works out the exact answers for points on an
	// axis, which bypass the iterations.
	rpc_prep #(
		.COORD_WIDTH(COORD_WIDTH),
		.DW(DW),
		.SW(SW)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req_type(req_type),
		.x_in(x_in),
		.y_in(y_in),
		.radius_in(radius_in),
		.angle_in(angle_in),
		.ctl(ctl_c[0]),
		.x(x_c[0]),
		.y(y_c[0]),
		.z(z_c[0]),
		.side(side_p)
	);

	// The row of cells: cell i performs the shift-and-add step by 2^-i and
	// hands its item to cell i+1 on the next clock.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		rpc_cell #(
			.DW(DW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_a(ctl_c[i]),
			.x_a(x_c[i]),
			.y_a(y_c[i]),
			.z_a(z_c[i]),
			.ctl_b(ctl_c[i+1]),
			.x_b(x_c[i+1]),
			.y_b(y_c[i+1]),
			.z_b(z_c[i+1])
		);
	end

	// The side information rides alongside the cells in a plain delay line so
	// that it meets its own item again at the back end.
	always_ff @(posedge clk) begin
		side_q[0] <= side_p;
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// Back end: gain correction of the magnitude, rounding of the phase and of
	// the rotated coordinates, saturation, and the registered result.
	rpc_post #(
		.COORD_WIDTH(COORD_WIDTH),
		.DW(DW),
		.SW(SW)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_c[CORDIC_STAGES]),
		.x(x_c[CORDIC_STAGES]),
		.y(y_c[CORDIC_STAGES]),
		.z(z_c[CORDIC_STAGES]),
		.side(side_q[CORDIC_STAGES-1]),
		.done(done),
		.radius_out(radius_out),
		.angle_out(angle_out),
		.x_out(x_out),
		.y_out(y_out),
		.kind_out(kind_out)
	);

endmodule

// ===== src/rpc_checker.sv =====
module rpc_checker
	import rpc_pkg::*;
#(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   req_type,
	input logic                   done,
	input logic [COORD_WIDTH-1:0] radius_out,
	input logic [ANGLE_W-1:0]     angle_out,
	input logic [COORD_WIDTH-1:0] x_out,
	input logic [COORD_WIDTH-1:0] y_out,
	input logic                   kind_out
);

	localparam int LAT = CORDIC_STAGES + 3;

	// Every accepted item produces a result on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item gave no result at the expected cycle");

	// No result appears without an item accepted at the matching cycle.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	// The kind of the result is that of the item it belongs to.
	a_kind_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (kind_out == $past(req_type, LAT)))
		else $error("result kind does not match its item");

	// Fields of the conversion not asked for are zero.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((kind_out == REQ_TO_RECT) ? (radius_out == '0 && angle_out == '0)
		                                    : (x_out == '0 && y_out == '0)))
		else $error("fields of the other conversion are not zero");

endmodule

bind rect_polar_converter rpc_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.CORDIC_STAGES(CORDIC_STAGES)
) u_rpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.req_type(req_type),
	.done(done),
	.radius_out(radius_out),
	.angle_out(angle_out),
	.x_out(x_out),
	.y_out(y_out),
	.kind_out(kind_out)
);
